@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The condition must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/efsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package efsd_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int TIME_BITS   = 32;
  localparam int ID_W        = $clog2(MAX_SERVERS);
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int SRV_W       = 5;
  localparam int CFG_W       = 5;
  localparam int DUR_W       = 16;

  typedef struct packed {
    logic [TIME_BITS-1:0] busy;
    logic [ID_W-1:0]      id;
  } efsd_key_t;

  typedef struct packed {
    logic            load;
    logic            move;
    efsd_key_t       k;
    logic [CNT_W-1:0] count;
  } efsd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOVE = 3'b010,
    ST_NEXT = 3'b100
  } efsd_state_t;

  // Order by busy-until time, then by server id.
  function automatic logic key_lt(input efsd_key_t a, input efsd_key_t b);
    key_lt = (a.busy < b.busy) || ((a.busy == b.busy) && (a.id < b.id));
  endfunction

endpackage
`default_nettype wire

@@ hdl/efsd_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module efsd_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  efsd_pkg::efsd_ctl_t        ctl,
  input  logic [efsd_pkg::ID_W-1:0]  cell_idx,
  input  logic                       is_pick,
  input  logic                       is_after,
  input  efsd_pkg::efsd_key_t        nb_key,
  input  logic                       nb_lt,
  output efsd_pkg::efsd_key_t        view_key,
  output logic                       lt,
  output logic                       active
);
  import efsd_pkg::*;

  efsd_key_t key_r, key_nxt, init_key;

  assign init_key.busy = '0;
  assign init_key.id   = cell_idx;

  assign view_key = ctl.load ? init_key : key_r;
  assign active   = (CNT_W'(view_key.id) < ctl.count);

  // Only cells right of the picked one compare their key against the moved entry.
  assign lt = is_after && key_lt(key_r, ctl.k);

  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = init_key;
    end else if (ctl.move) begin
      if (nb_lt) begin
        key_nxt = nb_key;
      end else if (is_pick || lt) begin
        key_nxt = ctl.k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= init_key;
    end else begin
      key_r <= key_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/earliest_free_server_dispatch_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Earliest-free server dispatch. The servers sit in a row of cells kept sorted
// by busy-until time and then by id, so the job goes to the first cell whose
// server is in use. In idle an accepted job picks the server and forms its new
// time, in move the entry shifts to its sorted place through the cell row, and
// in next, held while the output register keeps an unaccepted result, the next
// server is found and loaded there. A new job is taken once the state machine
// is back at idle, even while the previous result still waits in the output
// register. A job with restart set reloads all cells to zero times at
// acceptance. num_servers of 0 acts as 1, and one above the server count as it.
module earliest_free_server_dispatch_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  input  logic [efsd_pkg::DUR_W-1:0]    in_service_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efsd_pkg::SRV_W-1:0]    out_assigned_server,
  output logic [efsd_pkg::SRV_W-1:0]    out_next_server,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [efsd_pkg::CFG_W-1:0]    cfg_wdata
);
  import efsd_pkg::*;

  localparam int WIDE = CNT_W + CFG_W;

  efsd_state_t state_r, state_nxt;
  logic [CFG_W-1:0]        num_servers_r;
  efsd_key_t               k_r;
  logic [MAX_SERVERS-1:0]  pick_oh_r, after_r;
  logic                    sat_r;
  logic                    out_valid_r;
  logic [SRV_W-1:0]        out_assigned_r, out_next_r;
  logic                    out_sat_r;

  efsd_ctl_t               ctl;
  efsd_key_t               view_key [MAX_SERVERS];
  efsd_key_t               nb_key   [MAX_SERVERS];
  logic [MAX_SERVERS-1:0]  lt_w, nb_lt_w, active_w;
  logic [MAX_SERVERS-1:0]  first_oh, after_w;
  efsd_key_t               sel_key;
  logic [TIME_BITS:0]      sum;
  logic [CNT_W-1:0]        count;
  logic                    accept;
  logic                    out_load;
  logic [ID_W:0]           pick_id1, next_id1;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_NEXT) && (!out_valid_r || out_ready);

  always_comb begin
    if (num_servers_r == '0) begin
      count = CNT_W'(1);
    end else if (WIDE'(num_servers_r) > WIDE'(MAX_SERVERS)) begin
      count = CNT_W'(MAX_SERVERS);
    end else begin
      count = CNT_W'(num_servers_r);
    end
  end

  assign ctl.load  = accept && in_restart;
  assign ctl.move  = (state_r == ST_MOVE);
  assign ctl.k     = k_r;
  assign ctl.count = count;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SERVERS; gi++) begin : g_cell
      if (gi == MAX_SERVERS - 1) begin : g_last
        assign nb_key[gi]  = '0;
        assign nb_lt_w[gi] = 1'b0;
      end else begin : g_mid
        assign nb_key[gi]  = view_key[gi+1];
        assign nb_lt_w[gi] = lt_w[gi+1];
      end
      efsd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cell_idx (ID_W'(gi)),
        .is_pick  (pick_oh_r[gi]),
        .is_after (after_r[gi]),
        .nb_key   (nb_key[gi]),
        .nb_lt    (nb_lt_w[gi]),
        .view_key (view_key[gi]),
        .lt       (lt_w[gi]),
        .active   (active_w[gi])
      );
    end
  endgenerate

  // Lowest set bit: the first in-use server in sorted order.
  assign first_oh = active_w & ~(active_w - MAX_SERVERS'(1));
  assign after_w  = ~(first_oh | (first_oh - MAX_SERVERS'(1)));

  always_comb begin
    sel_key = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (first_oh[i]) begin
        sel_key = sel_key | view_key[i];
      end
    end
  end

  assign sum      = {1'b0, sel_key.busy} + (TIME_BITS+1)'(in_service_time);
  assign pick_id1 = {1'b0, k_r.id} + (ID_W+1)'(1);
  assign next_id1 = {1'b0, sel_key.id} + (ID_W+1)'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MOVE;
      end
      ST_MOVE: state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_servers_r <= CFG_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        num_servers_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k_r.id    <= sel_key.id;
      k_r.busy  <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
      sat_r     <= sum[TIME_BITS];
      pick_oh_r <= first_oh;
      after_r   <= after_w;
    end
    if (out_load) begin
      out_assigned_r <= SRV_W'(pick_id1);
      out_next_r     <= SRV_W'(next_id1);
      out_sat_r      <= sat_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_assigned_server = out_assigned_r;
  assign out_next_server     = out_next_r;
  assign out_saturated       = out_sat_r;

  // Cross-cell checks: the ids form a permutation and the row is sorted in idle.
  logic [MAX_SERVERS-1:0] id_seen;
  logic                   row_sorted;

  always_comb begin
    id_seen    = '0;
    row_sorted = 1'b1;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      id_seen[view_key[i].id] = 1'b1;
    end
    for (int i = 0; i < MAX_SERVERS - 1; i++) begin
      if (!key_lt(view_key[i], view_key[i+1])) row_sorted = 1'b0;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_ids_unique, clk, rst_n, (&id_seen))
  `ASSERT_CLK(a_sorted_idle, clk, rst_n, (state_r == ST_IDLE) |-> row_sorted)
  `ASSERT_CLK(a_pick_onehot, clk, rst_n, (state_r == ST_MOVE) |-> $onehot(pick_oh_r))
  `ASSERT_NEVER(a_no_active, clk, rst_n, (active_w == '0))

endmodule
`default_nettype wire
